// File: design/fcwa_pkg.sv
// fcwa_pkg: types and constants for the frame clock with window average.
// No dependencies.
`default_nettype none
package fcwa_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_TICKS,
    ST_SECS,
    ST_FPS,
    ST_FPS_WAIT,
    ST_AVG,
    ST_AVG_WAIT,
    ST_DONE
  } state_t;

  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_PAUSE     = 3'd1;
  localparam logic [2:0] OP_UNPAUSE   = 3'd2;
  localparam logic [2:0] OP_TOGGLE    = 3'd3;
  localparam logic [2:0] OP_MEASURE   = 3'd4;
  localparam logic [2:0] OP_FRAME_WIN = 3'd5;
  localparam logic [2:0] OP_FRAME     = 3'd6;

  localparam logic [7:0]  SIZE_RESET   = 8'd100;
  // floor(x/1000) == (x * SECS_RECIP) >> SECS_SHIFT for every 32-bit x
  localparam logic [31:0] SECS_RECIP   = 32'd274877907;
  localparam int          SECS_SHIFT   = 38;
  localparam logic [31:0] TICK_LIMIT   = 32'd1000;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

endpackage
`default_nettype wire

// File: design/fcwa_div.sv
// fcwa_div: restoring serial divider, one quotient bit per cycle.
// 32-bit dividend, DW-bit divisor; no package dependency.
`default_nettype none
module fcwa_div #(
  parameter int DW = 40
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [31:0]        quot
);

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [4:0]    cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;

  always_comb begin
    trial = {rem_r, q_r[31]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = DW'(trial - {1'b0, den_r});
      q_nxt   = {q_r[30:0], 1'b1};
    end else begin
      rem_nxt = trial[DW-1:0];
      q_nxt   = {q_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// File: design/frame_clock_with_window_average.sv
// Frame clock with sliding-window average fps: event decode, delta window,
// sequencer. Depends on fcwa_pkg and fcwa_div.
// Per beat: optional window push, ticks, seconds, a divider pass for fps, and one for the
// average when the window is over half full with a nonzero sum; none under one second.
// A beat is taken only once the last result is registered; in_ready only while idle.
// Synchronous active-low reset; the delta window memory is not cleared.
`default_nettype none
module frame_clock_with_window_average #(
  parameter int WINDOW_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_run_ticks,
  output logic [31:0]      out_elapsed_ticks,
  output logic [31:0]      out_frames_per_second,
  output logic [31:0]      out_average_fps,
  output logic             out_no_frames_error
);

  localparam int HW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 32 + FW;
  localparam int CW = (FW > 8) ? FW : 8;

  fcwa_pkg::state_t state_r, state_nxt;

  logic [7:0]    size_cfg_r;
  logic          running_r, halted_r, slow_r;
  logic [31:0]   start_r, pause_r, prev_r, last_delta_r, frame_cnt_r;
  logic [31:0]   now_r, elapsed_r, ticks_r, fps_r, avg_r;
  logic [63:0]   prod_r;
  logic [HW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [SW-1:0] sum_r;
  logic [31:0]   mem [WINDOW_DEPTH];
  logic [31:0]   rd_r;

  logic [CW-1:0] size_ext;
  logic [FW-1:0] size_use;
  logic          evict;
  logic [HW-1:0] head_new;
  logic [FW-1:0] fill_new;
  logic [FW:0]   slot_sum;
  logic [HW-1:0] slot;
  logic [31:0]   secs;
  logic [31:0]   cur;
  logic          accept, push, out_free;

  logic          div_start, div_done;
  logic [31:0]   div_num, div_quot;
  logic [SW-1:0] div_den;

  assign accept   = in_valid && in_ready;
  assign push     = (in_operation == fcwa_pkg::OP_FRAME_WIN) && !halted_r;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == fcwa_pkg::ST_IDLE);
  assign cur      = in_now_ms - start_r;
  assign secs     = {6'd0, prod_r[63:fcwa_pkg::SECS_SHIFT]};

  always_comb begin
    size_ext = CW'(size_cfg_r);
    if (size_cfg_r == 8'd0) begin
      size_use = FW'(1);
    end else if (size_ext > CW'(WINDOW_DEPTH)) begin
      size_use = FW'(WINDOW_DEPTH);
    end else begin
      size_use = FW'(size_ext);
    end
    evict = (fill_r >= size_use);
    if (evict) begin
      head_new = (head_r == HW'(WINDOW_DEPTH - 1)) ? '0 : head_r + HW'(1);
      fill_new = fill_r - FW'(1);
    end else begin
      head_new = head_r;
      fill_new = fill_r;
    end
    slot_sum = (FW + 1)'(head_new) + (FW + 1)'(fill_new);
    if (slot_sum >= (FW + 1)'(WINDOW_DEPTH)) begin
      slot = HW'(slot_sum - (FW + 1)'(WINDOW_DEPTH));
    end else begin
      slot = HW'(slot_sum);
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = {22'd0, fcwa_pkg::MS_PER_SEC} * 32'(fill_r);
    div_den   = sum_r;
    case (state_r)
      fcwa_pkg::ST_IDLE: begin
        if (accept) state_nxt = push ? fcwa_pkg::ST_PUSH : fcwa_pkg::ST_TICKS;
      end
      fcwa_pkg::ST_PUSH:  state_nxt = fcwa_pkg::ST_TICKS;
      fcwa_pkg::ST_TICKS: state_nxt = fcwa_pkg::ST_SECS;
      fcwa_pkg::ST_SECS:  state_nxt = fcwa_pkg::ST_FPS;
      fcwa_pkg::ST_FPS: begin
        div_num = frame_cnt_r;
        div_den = SW'(secs);
        if (secs == 32'd0) begin
          state_nxt = fcwa_pkg::ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = fcwa_pkg::ST_FPS_WAIT;
        end
      end
      fcwa_pkg::ST_FPS_WAIT: begin
        if (div_done) state_nxt = fcwa_pkg::ST_AVG;
      end
      fcwa_pkg::ST_AVG: begin
        if (fill_r > (size_use >> 1) && sum_r != '0) begin
          div_start = 1'b1;
          state_nxt = fcwa_pkg::ST_AVG_WAIT;
        end else begin
          state_nxt = fcwa_pkg::ST_DONE;
        end
      end
      fcwa_pkg::ST_AVG_WAIT: begin
        if (div_done) state_nxt = fcwa_pkg::ST_DONE;
      end
      fcwa_pkg::ST_DONE: begin
        if (out_free) state_nxt = fcwa_pkg::ST_IDLE;
      end
      default: state_nxt = fcwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcwa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  fcwa_div #(.DW(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    rd_r <= mem[head_r];
    if (state_r == fcwa_pkg::ST_PUSH) mem[slot] <= last_delta_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r   <= fcwa_pkg::SIZE_RESET;
      running_r    <= 1'b1;
      halted_r     <= 1'b0;
      slow_r       <= 1'b0;
      start_r      <= '0;
      pause_r      <= '0;
      prev_r       <= '0;
      last_delta_r <= '0;
      frame_cnt_r  <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) size_cfg_r <= cfg_wdata;
      if (accept) begin
        case (in_operation)
          fcwa_pkg::OP_START: begin
            running_r   <= 1'b1;
            halted_r    <= 1'b0;
            frame_cnt_r <= '0;
            start_r     <= in_now_ms;
            pause_r     <= in_now_ms;
          end
          fcwa_pkg::OP_PAUSE: begin
            if (running_r && !halted_r) begin
              pause_r  <= cur;
              halted_r <= 1'b1;
            end
          end
          fcwa_pkg::OP_UNPAUSE: begin
            if (running_r && halted_r) begin
              start_r  <= in_now_ms - pause_r;
              halted_r <= 1'b0;
            end
          end
          fcwa_pkg::OP_TOGGLE: begin
            if (running_r && !slow_r) begin
              pause_r <= cur;
              slow_r  <= 1'b1;
            end else if (running_r) begin
              start_r <= in_now_ms - pause_r;
              slow_r  <= 1'b0;
            end
          end
          fcwa_pkg::OP_MEASURE: begin
            if (!halted_r && !slow_r) begin
              last_delta_r <= cur - prev_r;
              prev_r       <= cur;
            end
          end
          fcwa_pkg::OP_FRAME_WIN, fcwa_pkg::OP_FRAME: begin
            if (!halted_r) frame_cnt_r <= frame_cnt_r + 32'd1;
          end
          default: ;
        endcase
      end
      if (state_r == fcwa_pkg::ST_PUSH) begin
        head_r <= head_new;
        fill_r <= fill_new + FW'(1);
        sum_r  <= sum_r - (evict ? SW'(rd_r) : '0) + SW'(last_delta_r);
      end
      if (state_r == fcwa_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now_ms;
      if (in_operation == fcwa_pkg::OP_MEASURE && !halted_r) begin
        elapsed_r <= slow_r ? 32'd1 : cur - prev_r;
      end else begin
        elapsed_r <= '0;
      end
    end
    if (state_r == fcwa_pkg::ST_TICKS) begin
      ticks_r <= halted_r ? pause_r : (slow_r ? 32'd1 : now_r - start_r);
    end
    if (state_r == fcwa_pkg::ST_SECS) prod_r <= 64'(ticks_r) * 64'(fcwa_pkg::SECS_RECIP);
    if (state_r == fcwa_pkg::ST_FPS) begin
      fps_r <= '0;
      avg_r <= '0;
    end
    if (state_r == fcwa_pkg::ST_FPS_WAIT && div_done) fps_r <= div_quot;
    if (state_r == fcwa_pkg::ST_AVG && fill_r > (size_use >> 1) && sum_r == '0) begin
      avg_r <= '1;
    end
    if (state_r == fcwa_pkg::ST_AVG_WAIT && div_done) avg_r <= div_quot;
    if (state_r == fcwa_pkg::ST_DONE && out_free) begin
      out_run_ticks         <= ticks_r;
      out_elapsed_ticks     <= elapsed_r;
      out_frames_per_second <= fps_r;
      out_average_fps       <= avg_r;
      out_no_frames_error   <= (ticks_r > fcwa_pkg::TICK_LIMIT) && (frame_cnt_r == 32'd0);
    end
  end

endmodule
`default_nettype wire
